/* rtl/bcdscan_pkg.sv */
// ----------------------------------------------------------------------------
// bcdscan_pkg
// Shared types and constants for the binary to BCD display scanner.
// ----------------------------------------------------------------------------
package bcdscan_pkg;

    localparam int MAX_DIGITS_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int VALUE_PORT_W = 32;
    localparam int COUNT_W      = 4;
    localparam int DIGIT_W      = 4;
    localparam int SELECT_W     = 3;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

    // Register index, taken from paddr[2].
    localparam logic REG_DIGIT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

endpackage

/* rtl/bcdscan_datapath.sv */
// ----------------------------------------------------------------------------
// bcdscan_datapath
// Double-dabble shift register and digit selection.
// ----------------------------------------------------------------------------
module bcdscan_datapath #(
    parameter int VALUE_WIDTH = bcdscan_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_BCD     = 10,
    parameter int POS_W       = 4
) (
    input  logic                                i_clk,
    input  bcdscan_pkg::t_dp_cmd                i_cmd,
    input  logic [bcdscan_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [POS_W-1:0]                    i_pos,
    output logic [bcdscan_pkg::DIGIT_W-1:0]     o_digit
);

    localparam int BCD_W = NUM_BCD * bcdscan_pkg::DIGIT_W;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       n_adjusted;

    // Each digit of five or more gets three added before the shift.
    always_comb begin
        for (int d = 0; d < NUM_BCD; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adjusted[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adjusted[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value[VALUE_WIDTH-1:0];
            r_bcd   <= '0;
        end else if (i_cmd.step) begin
            r_value <= {r_value[VALUE_WIDTH-2:0], 1'b0};
            r_bcd   <= {n_adjusted[BCD_W-2:0], r_value[VALUE_WIDTH-1]};
        end
    end

    assign o_digit = r_bcd[i_pos*4 +: 4];

endmodule

/* rtl/bcdscan_ctrl.sv */
// ----------------------------------------------------------------------------
// bcdscan_ctrl
// Sequencer for conversion and the digit strobe scan.
// ----------------------------------------------------------------------------
module bcdscan_ctrl #(
    parameter int VALUE_WIDTH = bcdscan_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = bcdscan_pkg::MAX_DIGITS_DEF,
    parameter int POS_W       = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [bcdscan_pkg::COUNT_W-1:0]    i_count,
    output logic                               o_valid,
    input  logic                               i_stall,
    output bcdscan_pkg::t_dp_cmd               o_cmd,
    output logic [POS_W-1:0]                   o_pos,
    output logic [bcdscan_pkg::SELECT_W-1:0]   o_select,
    output logic                               o_last
);

    localparam int BIT_W = $clog2(VALUE_WIDTH + 1);
    localparam int SEL_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    bcdscan_pkg::t_state r_state, n_state;
    logic [BIT_W-1:0] r_bits, n_bits;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [SEL_W-1:0] r_sel, n_sel;
    logic [bcdscan_pkg::COUNT_W-1:0] w_clamped;
    logic w_accept;

    always_comb begin
        if (i_count == '0) begin
            w_clamped = bcdscan_pkg::COUNT_W'(1);
        end else if (i_count > bcdscan_pkg::COUNT_W'(MAX_DIGITS)) begin
            w_clamped = bcdscan_pkg::COUNT_W'(MAX_DIGITS);
        end else begin
            w_clamped = i_count;
        end
    end

    assign o_stall  = (r_state != bcdscan_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcdscan_pkg::ST_IDLE;
            r_bits  <= '0;
            r_pos   <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_pos   <= n_pos;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_bits     = r_bits;
        n_pos      = r_pos;
        n_sel      = r_sel;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_valid    = 1'b0;
        unique case (r_state)
            bcdscan_pkg::ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_bits     = BIT_W'(VALUE_WIDTH);
                    n_pos      = POS_W'(w_clamped - bcdscan_pkg::COUNT_W'(1));
                    n_sel      = '0;
                    n_state    = bcdscan_pkg::ST_CONVERT;
                end
            end
            bcdscan_pkg::ST_CONVERT: begin
                o_cmd.step = 1'b1;
                n_bits     = r_bits - BIT_W'(1);
                if (r_bits == BIT_W'(1)) begin
                    n_state = bcdscan_pkg::ST_SCAN;
                end
            end
            bcdscan_pkg::ST_SCAN: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (r_pos == '0) begin
                        n_state = bcdscan_pkg::ST_IDLE;
                    end else begin
                        n_pos = r_pos - POS_W'(1);
                        n_sel = r_sel + SEL_W'(1);
                    end
                end
            end
            default: begin
                n_state = bcdscan_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_pos    = r_pos;
    assign o_select = bcdscan_pkg::SELECT_W'(r_sel);
    assign o_last   = (r_pos == '0);

    a_load_starts_convert : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == bcdscan_pkg::ST_CONVERT) && (r_bits == BIT_W'(VALUE_WIDTH)))
        else $error("conversion did not start with a full bit count");

    a_convert_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcdscan_pkg::ST_CONVERT) && (r_bits == BIT_W'(1))
        |=> (r_state == bcdscan_pkg::ST_SCAN))
        else $error("scan did not follow the final conversion step");

    a_last_returns_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcdscan_pkg::ST_SCAN) && (r_pos == '0) && !i_stall
        |=> (r_state == bcdscan_pkg::ST_IDLE))
        else $error("block did not return to idle after the last digit");

endmodule

/* rtl/binary_to_bcd_display_scan.sv */
// ----------------------------------------------------------------------------
// binary_to_bcd_display_scan
// Each request carries a binary value. It is converted to BCD by a
// double-dabble shifter that takes one bit of the value per clock; the
// conversion runs in ST_CONVERT, after the cycle in which the request
// is taken. The lowest digit_count decimal digits are then presented one per
// result request, most significant first, with the strobe index (0 for the
// most significant digit shown) and a flag on the final digit. Higher digits
// are dropped, so the value wraps modulo ten to the power of the digit count.
// A digit count of zero shows one digit and a count above MAX_DIGITS shows
// MAX_DIGITS. One value is handled at a time: the input stays stalled until
// the final digit is taken, and the strobe scan shows one digit per cycle
// while the output is not stalled. The digit count register sits at byte
// address 0 of the APB port and resets to 3.
// ----------------------------------------------------------------------------
module binary_to_bcd_display_scan #(
    parameter int MAX_DIGITS  = bcdscan_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = bcdscan_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input request channel.
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [bcdscan_pkg::VALUE_PORT_W-1:0]   i_value,
    // Result request channel.
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [bcdscan_pkg::DIGIT_W-1:0]        o_bcd_digit,
    output logic [bcdscan_pkg::SELECT_W-1:0]       o_digit_select,
    output logic                                   o_last_digit,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bcdscan_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bcdscan_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bcdscan_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                   pready
);

    // Enough BCD digits to hold any VALUE_WIDTH-bit number, and never fewer
    // than the largest digit count, so that leading zeros can be shown.
    localparam int BCD_NEEDED = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int NUM_BCD    = (BCD_NEEDED > MAX_DIGITS) ? BCD_NEEDED : MAX_DIGITS;
    localparam int POS_W      = $clog2(NUM_BCD);

    logic [bcdscan_pkg::COUNT_W-1:0] r_digit_count;
    logic                            w_reg_sel;
    bcdscan_pkg::t_dp_cmd            w_cmd;
    logic [POS_W-1:0]                w_pos;

    // The register index is bit 2 of the byte address; the low bits are the
    // byte lanes and are ignored.
    assign w_reg_sel = (paddr[2] == bcdscan_pkg::REG_DIGIT_COUNT);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= bcdscan_pkg::COUNT_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_digit_count <= pwdata[bcdscan_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_sel) begin
            prdata[bcdscan_pkg::COUNT_W-1:0] = r_digit_count;
        end
    end

    // The controller sequences the load, the shift steps and the strobe scan;
    // the clamped count is captured when a request is taken, so the register
    // may be rewritten freely while the block is idle.
    bcdscan_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS),
        .POS_W       (POS_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_count  (r_digit_count),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (w_cmd),
        .o_pos    (w_pos),
        .o_select (o_digit_select),
        .o_last   (o_last_digit)
    );

    // The datapath holds the shifting value and the BCD digits; the digit
    // shown is picked by the position the controller counts down.
    bcdscan_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_BCD     (NUM_BCD),
        .POS_W       (POS_W)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_value (i_value),
        .i_pos   (w_pos),
        .o_digit (o_bcd_digit)
    );

endmodule
